### hdl/supset_pkg.sv
// Shared types and codes for the sorted unique pair set.
`default_nettype none
package supset_pkg;

    // Function codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // One stored pair
    typedef struct packed {
        logic [7:0]  mask;
        logic [31:0] rel;
    } t_pair;

    // Input item
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  insert_mask;
        logic [31:0] insert_rel;
        logic [3:0]  read_index;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic        already_present;
        logic        overflow;
        logic        entry_valid;
        logic [7:0]  entry_mask;
        logic [31:0] entry_rel;
        logic [4:0]  count;
    } t_result;

    // Per-cell status toward the top level
    typedef struct packed {
        logic after;   // slot lies at or past the insert position
        logic match;   // occupied slot equals the new pair
    } t_cell_stat;

endpackage
`default_nettype wire

### hdl/supset_cell.sv
// One slot of the sorted chain: compare against the new pair and shift on insert.
`default_nettype none
module supset_cell
    import supset_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_occ,
    input  wire logic       i_ins,
    input  wire t_pair      i_new,
    input  wire t_pair      i_prev,
    input  wire logic       i_prev_after,
    output t_pair           o_pair,
    output t_cell_stat      o_stat
);

    t_pair r_pair;
    t_pair n_pair;
    logic  stored_after;
    logic  stored_eq;

    // Order: rel descending, then mask ascending
    assign stored_after = (r_pair.rel < i_new.rel) ||
                          ((r_pair.rel == i_new.rel) && (r_pair.mask > i_new.mask));
    assign stored_eq    = (r_pair == i_new);

    assign o_stat.after = !i_occ || stored_after;
    assign o_stat.match = i_occ && stored_eq;
    assign o_pair       = r_pair;

    // Shift from the neighbor below the insert point, drop the new pair at it
    always_comb begin
        n_pair = r_pair;
        if (i_ins && o_stat.after) begin
            n_pair = i_prev_after ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

endmodule
`default_nettype wire

### hdl/sorted_unique_pair_set_core.sv
// Top level of the sorted unique pair set: cell chain, count and result register.
// A bounded set of (mask, rel) pairs kept in order of rel descending, then mask
// ascending, with no duplicates. Each command (insert, read, clear) is accepted
// when i_start is high and o_busy is low, and its result appears on o_result for
// exactly one cycle with o_done high, in the cycle after acceptance. o_busy is
// never raised, so a command may be issued every cycle; this rate holds because
// the row of slot cells compares against the new pair and shifts in parallel. The
// receiver must take each result when it is shown. Inserting into a full set
// drops the pair and flags overflow; a pair already present is reported as such
// even when the set is full.
`default_nettype none
module sorted_unique_pair_set_core
    import supset_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_cmd    i_cmd,
    output logic         o_busy,
    output logic         o_done,
    output t_result      o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_done;
    t_result             r_result;
    t_result             n_result;

    logic                accept;
    logic                found;
    logic                full;
    logic                do_ins;
    t_pair               new_pair;
    t_pair               cell_pair  [CAPACITY];
    t_cell_stat          cell_stat  [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [IW-1:0]       rd_sel;
    logic                rd_ok;
    logic [31:0]         count_wide;

    assign accept   = i_start && !o_busy;
    assign o_busy   = 1'b0;
    assign new_pair = '{mask: i_cmd.insert_mask, rel: i_cmd.insert_rel};
    assign full     = (r_count >= CW'(CAPACITY));
    assign found    = |match_vec;
    assign do_ins   = accept && (i_cmd.func == FUNC_INSERT) && !found && !full;

    // Chain of slot cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic occ;
        assign occ = (CW'(g) < r_count);
        if (g == 0) begin : g_head
            supset_cell u_cell (
                .i_clk        (i_clk),
                .i_occ        (occ),
                .i_ins        (do_ins),
                .i_new        (new_pair),
                .i_prev       (new_pair),
                .i_prev_after (1'b0),
                .o_pair       (cell_pair[g]),
                .o_stat       (cell_stat[g])
            );
        end else begin : g_body
            supset_cell u_cell (
                .i_clk        (i_clk),
                .i_occ        (occ),
                .i_ins        (do_ins),
                .i_new        (new_pair),
                .i_prev       (cell_pair[g-1]),
                .i_prev_after (cell_stat[g-1].after),
                .o_pair       (cell_pair[g]),
                .o_stat       (cell_stat[g])
            );
        end
        assign match_vec[g] = cell_stat[g].match;
    end

    // Read select
    assign rd_sel = IW'(i_cmd.read_index);
    assign rd_ok  = ({28'd0, i_cmd.read_index} < 32'(CAPACITY)) &&
                    ((CW + 4)'(i_cmd.read_index) < (CW + 4)'(r_count));

    // Next count and result fields
    always_comb begin
        n_count  = r_count;
        n_result = '0;
        if (accept) begin
            case (i_cmd.func)
                FUNC_INSERT: begin
                    if (found) begin
                        n_result.already_present = 1'b1;
                    end else if (full) begin
                        n_result.overflow = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                FUNC_READ: begin
                    if (rd_ok) begin
                        n_result.entry_valid = 1'b1;
                        n_result.entry_mask  = cell_pair[rd_sel].mask;
                        n_result.entry_rel   = cell_pair[rd_sel].rel;
                    end
                end
                FUNC_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
        count_wide     = 32'(n_count);
        n_result.count = count_wide[4:0];
    end

    // Count, strobe and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("result strobe missing after accepted command");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.already_present && o_result.overflow))
        else $error("present and overflow raised together");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.overflow) |-> (r_count == CW'(CAPACITY)))
        else $error("overflow reported while set not full");

endmodule
`default_nettype wire

### tb/sv/tb_sorted_unique_pair_set_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted unique pair set core.
module tb_sorted_unique_pair_set_core;
    import supset_pkg::*;

    localparam int SET_DEPTH   = 16;
    localparam int NUM_ITEMS   = 1850;
    localparam int CYCLE_LIMIT = 400000;

    // Function code with no operation behind it
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // One queued command with its lead-in gap and an optional drain hold-off
    typedef struct {
        t_cmd        cmd;
        int unsigned gap;
        bit          drain;
    } t_stim;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    t_stim   pending_cmds[$];
    t_result expected_results[$];
    t_pair   shadow_pairs[SET_DEPTH];
    int      shadow_count = 0;
    int      fail_count   = 0;
    int      gap_wait     = 0;
    int      cycle_count  = 0;

    sorted_unique_pair_set_core #(
        .CAPACITY (SET_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the pair set: applies one command, returns its result
    function automatic t_result set_apply(input t_cmd c);
        t_result r;
        int      pos;
        bit      found;
        r     = '0;
        pos   = 0;
        found = 1'b0;
        case (c.func)
            FUNC_INSERT: begin
                // sorted store: entries ahead of the new pair form a prefix
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_pairs[i].rel > c.insert_rel ||
                        (shadow_pairs[i].rel == c.insert_rel &&
                         shadow_pairs[i].mask < c.insert_mask))
                        pos++;
                    if (shadow_pairs[i].rel == c.insert_rel &&
                        shadow_pairs[i].mask == c.insert_mask)
                        found = 1'b1;
                end
                if (found) begin
                    r.already_present = 1'b1;
                end else if (shadow_count >= SET_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_pairs[i] = shadow_pairs[i-1];
                    shadow_pairs[pos].mask = c.insert_mask;
                    shadow_pairs[pos].rel  = c.insert_rel;
                    shadow_count++;
                end
            end
            FUNC_READ: begin
                if (int'(c.read_index) < shadow_count) begin
                    r.entry_valid = 1'b1;
                    r.entry_mask  = shadow_pairs[c.read_index].mask;
                    r.entry_rel   = shadow_pairs[c.read_index].rel;
                end
            end
            FUNC_CLEAR: begin
                shadow_count = 0;
            end
            default: ;
        endcase
        r.count = shadow_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic queue_cmd(input logic [1:0] fn, input logic [7:0] m, input logic [31:0] rl,
                             input logic [3:0] idx, input int unsigned gap, input bit drain);
        t_stim s;
        s.cmd.func        = fn;
        s.cmd.insert_mask = m;
        s.cmd.insert_rel  = rl;
        s.cmd.read_index  = idx;
        s.gap             = gap;
        s.drain           = drain;
        pending_cmds.push_back(s);
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input int style);
        int unsigned r;
        if (style == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Driver: presents queued commands, one transfer per accepted start
    always @(posedge i_clk) begin : drive_proc
        t_stim nxt;
        logic  start_nxt;
        logic  in_flight;
        start_nxt = i_start;
        // a transfer taken at this edge still owes its result
        in_flight = i_start && !o_busy;
        if (!i_rst_n) begin
            start_nxt = 1'b0;
        end else begin
            if (i_start && !o_busy)
                start_nxt = 1'b0;
            if (!start_nxt && pending_cmds.size() != 0) begin
                if (pending_cmds[0].drain &&
                    (expected_results.size() != 0 || in_flight)) begin
                    gap_wait = 0;
                end else if (gap_wait < int'(pending_cmds[0].gap)) begin
                    gap_wait++;
                end else begin
                    nxt       = pending_cmds.pop_front();
                    i_cmd     <= nxt.cmd;
                    start_nxt = 1'b1;
                    gap_wait  = 0;
                end
            end
        end
        i_start <= start_nxt;
    end

    // Monitor: check the shown result, then predict for a newly accepted command
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_result.count), '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.already_present !== want.already_present)
                    report_mismatch("already_present", 32'(o_result.already_present),
                                    32'(want.already_present));
                if (o_result.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_result.overflow),
                                    32'(want.overflow));
                if (o_result.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 32'(o_result.entry_valid),
                                    32'(want.entry_valid));
                if (o_result.entry_mask !== want.entry_mask)
                    report_mismatch("entry_mask", 32'(o_result.entry_mask),
                                    32'(want.entry_mask));
                if (o_result.entry_rel !== want.entry_rel)
                    report_mismatch("entry_rel", o_result.entry_rel, want.entry_rel);
                if (o_result.count !== want.count)
                    report_mismatch("count", 32'(o_result.count), 32'(want.count));
            end
        end
        if (i_rst_n && i_start && !o_busy)
            expected_results.push_back(set_apply(i_cmd));
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        int          phase_len;
        int          gap_style;
        bit          use_pool;
        bit          first_phase;
        int unsigned r;
        logic [31:0] rel_pool[5];
        logic [7:0]  mask_pool[4];
        logic [1:0]  fn;
        logic [7:0]  m;
        logic [31:0] rl;

        // Directed: empty set, field extremes, ties, duplicates, reads, unused code
        queue_cmd(FUNC_CLEAR,  8'h00, 32'h0000_0000, 4'd0,  0, 0);
        queue_cmd(FUNC_READ,   8'hFF, 32'hFFFF_FFFF, 4'd0,  0, 0);
        queue_cmd(FUNC_INSERT, 8'h00, 32'h0000_0000, 4'hF,  0, 0);
        queue_cmd(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 4'd0,  0, 0);
        queue_cmd(FUNC_INSERT, 8'h00, 32'hFFFF_FFFF, 4'd0,  1, 0);
        queue_cmd(FUNC_INSERT, 8'hFF, 32'h0000_0000, 4'd0,  0, 0);
        queue_cmd(FUNC_INSERT, 8'h00, 32'h0000_0000, 4'd0,  0, 0);
        queue_cmd(FUNC_INSERT, 8'h80, 32'h8000_0000, 4'd0,  2, 0);
        queue_cmd(FUNC_INSERT, 8'h7F, 32'h8000_0000, 4'd0,  0, 0);
        for (int i = 0; i < 7; i++)
            queue_cmd(FUNC_READ, 8'($urandom), $urandom, i[3:0], 0, 0);
        queue_cmd(FUNC_READ,   8'h00, 32'h0000_0000, 4'hF,  0, 0);
        queue_cmd(FUNC_SPARE,  8'hFF, 32'hFFFF_FFFF, 4'hF,  0, 0);
        queue_cmd(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 4'd0,  0, 0);
        queue_cmd(FUNC_CLEAR,  8'hFF, 32'hFFFF_FFFF, 4'hF,  0, 0);
        queue_cmd(FUNC_READ,   8'h00, 32'h0000_0000, 4'd0,  0, 0);

        // Random phases: small value pools for duplicates and ties, or open values
        first_phase = 1'b1;
        while (pending_cmds.size() < NUM_ITEMS) begin
            phase_len = $urandom_range(20, 80);
            gap_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
            use_pool  = 1'($urandom_range(0, 1));
            for (int i = 0; i < 5; i++) begin
                case ($urandom_range(0, 5))
                    0:       rel_pool[i] = 32'h0000_0000;
                    1:       rel_pool[i] = 32'hFFFF_FFFF;
                    2:       rel_pool[i] = 32'h8000_0000;
                    default: rel_pool[i] = $urandom;
                endcase
            end
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(0, 4))
                    0:       mask_pool[i] = 8'h00;
                    1:       mask_pool[i] = 8'hFF;
                    default: mask_pool[i] = 8'($urandom);
                endcase
            end
            for (int k = 0; k < phase_len && pending_cmds.size() < NUM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    fn = FUNC_INSERT;
                else if (r < 95)
                    fn = FUNC_READ;
                else if (r < 97)
                    fn = FUNC_CLEAR;
                else
                    fn = FUNC_SPARE;
                if (use_pool) begin
                    m  = mask_pool[$urandom_range(0, 3)];
                    rl = rel_pool[$urandom_range(0, 4)];
                end else begin
                    m  = 8'($urandom);
                    rl = $urandom;
                end
                queue_cmd(fn, m, rl, 4'($urandom_range(0, 15)), pick_gap(gap_style),
                          k == 0 && (first_phase || $urandom_range(0, 3) == 0));
                first_phase = 1'b0;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all commands accepted and every result seen
        while (pending_cmds.size() != 0 || i_start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
